/* design/text_console_writer_unit_macros.svh */
// Assertion macros used by the console writer controller (tcw_ctrl).
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define TCW_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tcw_pkg.sv */
package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS     = COLUMNS * ROWS;
	localparam int TAB_SHIFT = $clog2(TAB_WIDTH);

	// Field widths.
	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int ADDR_W  = 11;
	localparam int CELL_W  = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	// Opcodes.
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Control characters.
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// One cycle of frame memory traffic.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} tcw_ram_req_t;

	// Finished result handed to the output register.
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] location;
		logic [CELL_W-1:0] data;
		logic              scrolled;
	} tcw_result_t;

	// Maps a screen row to its row in memory, which rotates by one on every scroll.
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
			input logic [ROW_W-1:0] base);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, base};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	// Linear cell address of a row and column.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

/* design/tcw_frame_ram.sv */
module tcw_frame_ram
	import tcw_pkg::*;
(
	input  logic              clk,
	input  tcw_ram_req_t      req,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELLS];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* design/tcw_ctrl.sv */
`include "text_console_writer_unit_macros.svh"

module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] back_color,
	input  logic [COLOR_W-1:0] fore_color,
	input  logic [ADDR_W-1:0]  cell_index,
	output tcw_ram_req_t       ram_req,
	input  logic [CELL_W-1:0]  ram_rdata,
	output logic               res_valid,
	input  logic               res_take,
	output tcw_result_t        res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_MOVE  = 3'd3;
	localparam logic [2:0] ST_RDIV  = 3'd4;
	localparam logic [2:0] ST_RWAIT = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]             state_q;
	logic [OP_W-1:0]        op_q;
	logic [CHAR_W-1:0]      ch_q;
	logic [2*COLOR_W-1:0]   attr_q;
	logic [ADDR_W-1:0]      rem_q;
	logic [ROW_W-1:0]       rrow_q;
	logic                   rvalid_q;
	logic [COL_W-1:0]       cur_col_q;
	logic [ROW_W-1:0]       cur_row_q;
	logic [ROW_W-1:0]       base_q;
	logic [ROWS-1:0]        row_valid_q;
	logic [COL_W-1:0]       sweep_col_q;
	logic [CELL_W-1:0]      data_q;
	logic                   scrolled_q;

	logic                   printable;
	logic [ROW_W-1:0]       prow_cur;
	logic [ROW_W-1:0]       prow_rd;
	logic [CELL_W-1:0]      put_cell;
	logic [COL_W:0]         col_n;
	logic [ROW_W:0]         row_n;
	logic                   scroll;

	assign printable = (ch_q[CHAR_W-1] == 1'b0) && (ch_q >= CH_SPACE);
	assign prow_cur  = phys_row(cur_row_q, base_q);
	assign prow_rd   = phys_row(rrow_q, base_q);
	assign put_cell  = {attr_q, ch_q};

	// Next cursor position for a put, with wrap and scroll.
	always_comb begin
		col_n  = {1'b0, cur_col_q};
		row_n  = {1'b0, cur_row_q};
		scroll = 1'b0;
		priority if (ch_q == CH_BS) begin
			if (cur_col_q != '0) begin
				col_n = col_n - 1'b1;
			end
		end else if (ch_q == CH_TAB) begin
			col_n = ((col_n >> TAB_SHIFT) + 1'b1) << TAB_SHIFT;
		end else if (ch_q == CH_CR) begin
			col_n = '0;
		end else if (ch_q == CH_LF) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end else if (printable) begin
			col_n = col_n + 1'b1;
		end else begin
			// Other control bytes and bytes with the top bit set leave the cursor alone.
			col_n = {1'b0, cur_col_q};
		end
		if (col_n >= (COL_W+1)'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
		if (row_n >= (ROW_W+1)'(ROWS)) begin
			row_n  = (ROW_W+1)'(ROWS - 1);
			scroll = 1'b1;
		end
	end

	// Memory traffic: single writes, row sweeps and reads.
	always_comb begin
		ram_req = '0;
		unique case (state_q)
			ST_EXEC: begin
				if ((op_q == OP_PUT) && printable && row_valid_q[prow_cur]) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = cell_addr(prow_cur, cur_col_q);
					ram_req.wdata = put_cell;
				end
			end
			ST_SWEEP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cell_addr(prow_cur, sweep_col_q);
				ram_req.wdata = (sweep_col_q == cur_col_q) ? put_cell : BLANK_CELL;
			end
			ST_RDIV: begin
				if (rem_q < ADDR_W'(COLUMNS)) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = cell_addr(prow_rd, rem_q[COL_W-1:0]);
				end
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	// Sequencer and cursor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			base_q      <= '0;
			row_valid_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q)
						OP_PUT: begin
							if (printable && !row_valid_q[prow_cur]) begin
								state_q <= ST_SWEEP;
							end else begin
								state_q <= ST_MOVE;
							end
						end
						OP_CLEAR: begin
							row_valid_q <= '0;
							cur_col_q   <= '0;
							cur_row_q   <= '0;
							state_q     <= ST_DONE;
						end
						OP_READ: begin
							if (rem_q >= ADDR_W'(CELLS)) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_RDIV;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SWEEP: begin
					if (sweep_col_q == COL_W'(COLUMNS - 1)) begin
						row_valid_q[prow_cur] <= 1'b1;
						state_q               <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					cur_col_q <= col_n[COL_W-1:0];
					cur_row_q <= row_n[ROW_W-1:0];
					if (scroll) begin
						// The old top row becomes the new bottom row and reads blank.
						row_valid_q[base_q] <= 1'b0;
						base_q <= phys_row(base_q, ROW_W'(1));
					end
					state_q <= ST_DONE;
				end
				ST_RDIV: begin
					if (rem_q < ADDR_W'(COLUMNS)) begin
						state_q <= ST_RWAIT;
					end
				end
				ST_RWAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item fields and working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q        <= opcode;
				ch_q        <= char_code;
				attr_q      <= {back_color, fore_color};
				rem_q       <= cell_index;
				rrow_q      <= '0;
				sweep_col_q <= '0;
				data_q      <= '0;
				scrolled_q  <= 1'b0;
			end
			ST_SWEEP: begin
				sweep_col_q <= sweep_col_q + 1'b1;
			end
			ST_MOVE: begin
				scrolled_q <= scroll;
			end
			ST_RDIV: begin
				// Split the cell index into row and column, one row per cycle.
				if (rem_q >= ADDR_W'(COLUMNS)) begin
					rem_q  <= rem_q - ADDR_W'(COLUMNS);
					rrow_q <= rrow_q + 1'b1;
				end else begin
					rvalid_q <= row_valid_q[prow_rd];
				end
			end
			ST_RWAIT: begin
				data_q <= rvalid_q ? ram_rdata : BLANK_CELL;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign res_valid     = (state_q == ST_DONE);
	assign res.col       = cur_col_q;
	assign res.row       = cur_row_q;
	assign res.location  = cell_addr(cur_row_q, cur_col_q);
	assign res.data      = data_q;
	assign res.scrolled  = scrolled_q;

	`TCW_ASSERT(a_col_range, cur_col_q < COL_W'(COLUMNS), "cursor column out of range")
	`TCW_ASSERT(a_row_range, cur_row_q < ROW_W'(ROWS), "cursor row out of range")
	`TCW_ASSERT(a_no_rw_overlap, !(ram_req.we && ram_req.re), "read and write in one cycle")
	`TCW_IMPLY(a_scroll_blanks, (state_q == ST_MOVE) && scroll,
		!row_valid_q[$past(base_q)], "scrolled-in row not blanked")
	`TCW_IMPLY(a_sweep_marks, (state_q == ST_SWEEP) && (sweep_col_q == COL_W'(COLUMNS - 1)),
		row_valid_q[prow_cur], "swept row not marked valid")

endmodule

/* design/text_console_writer_unit.sv */
// Text console writer: an 80x25 screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor.
// Input channel: in_valid/in_stall carry one beat per item: opcode (put, clear,
// read), char_code, back_color, fore_color and cell_index.
// Output channel: out_valid/out_stall carry one result beat per item: the
// cursor after the item, the cell read (zero for other opcodes and out-of-range
// reads) and whether a put scrolled the screen.
// Items are handled one at a time. Once accepted, a clear, an out-of-range
// read and the unused opcode go straight to the result; any other put byte
// moves the cursor, and a printable character whose row is written first
// after a reset, clear or scroll has that row swept with blanks beforehand
// at one cell per cycle on the memory write port. An in-range read has its
// index split into row and column one row per cycle before the registered
// memory read. The next item is accepted once the result has moved into the
// output register. A scroll only rotates the row mapping and needs no extra pass.
// Reset marks every row blank and homes the cursor; no clearing pass is run,
// so the block accepts an item right after reset.
// The next item is accepted while a result beat waits under out_stall; it is
// finished up to its result and then waits until the output register frees.
module text_console_writer_unit
	import tcw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] back_color,
	input  logic [COLOR_W-1:0] fore_color,
	input  logic [ADDR_W-1:0]  cell_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COL_W-1:0]   cursor_col,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [ADDR_W-1:0]  cursor_location,
	output logic [CELL_W-1:0]  cell_data,
	output logic               scrolled
);

	tcw_ram_req_t      ram_req;
	logic [CELL_W-1:0] ram_rdata;
	logic              res_valid;
	logic              res_take;
	tcw_result_t       res;
	logic              out_valid_q;
	tcw_result_t       out_q;

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.char_code  (char_code),
		.back_color (back_color),
		.fore_color (fore_color),
		.cell_index (cell_index),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	tcw_frame_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Output register: loads when empty or when its beat leaves this cycle.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_col      = out_q.col;
	assign cursor_row      = out_q.row;
	assign cursor_location = out_q.location;
	assign cell_data       = out_q.data;
	assign scrolled        = out_q.scrolled;

endmodule

/* verif/console_result_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the console writer, keeps a shadow copy of the
// screen and cursor, predicts one result per accepted item and compares every
// result beat with the oldest prediction.
module console_result_checker
	import tcw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] back_color,
	input  logic [COLOR_W-1:0] fore_color,
	input  logic [ADDR_W-1:0]  cell_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [COL_W-1:0]   cursor_col,
	input  logic [ROW_W-1:0]   cursor_row,
	input  logic [ADDR_W-1:0]  cursor_location,
	input  logic [CELL_W-1:0]  cell_data,
	input  logic               scrolled,
	output int                 mismatches,
	output int                 outstanding,
	output int                 results_seen,
	output int                 scrolls_seen
);

	logic [CELL_W-1:0] shadow_screen [CELLS];
	int                shadow_col;
	int                shadow_row;
	tcw_result_t       pending_results [$];
	int                error_total;
	int                result_total;
	int                scroll_total;

	// Fills every cell of the shadow screen with a blank.
	function automatic void blank_screen();
		int i;
		for (i = 0; i < CELLS; i++) begin
			shadow_screen[i] = BLANK_CELL;
		end
	endfunction

	// Applies one item to the shadow screen and cursor and returns the result
	// the block should report for it.
	function automatic tcw_result_t predict_console_result(input logic [OP_W-1:0] op,
			input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] bg,
			input logic [COLOR_W-1:0] fg, input logic [ADDR_W-1:0] idx);
		tcw_result_t       res;
		int                col;
		int                row;
		int                i;
		logic              did_scroll;
		logic [CELL_W-1:0] read_value;
		col        = shadow_col;
		row        = shadow_row;
		did_scroll = 1'b0;
		read_value = '0;
		case (op)
			OP_PUT: begin
				if (ch == CH_BS) begin
					if (col != 0) begin
						col--;
					end
				end else if (ch == CH_TAB) begin
					col = (col / TAB_WIDTH + 1) * TAB_WIDTH;
				end else if (ch == CH_CR) begin
					col = 0;
				end else if (ch == CH_LF) begin
					col = 0;
					row++;
				end else if (ch >= CH_SPACE && !ch[CHAR_W-1]) begin
					shadow_screen[row * COLUMNS + col] = {bg, fg, ch};
					col++;
				end
				// A column past the right edge wraps onto the next row.
				if (col >= COLUMNS) begin
					col = 0;
					row++;
				end
				// Running off the bottom moves everything up one row.
				if (row >= ROWS) begin
					for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
						shadow_screen[i] = shadow_screen[i + COLUMNS];
					end
					for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
						shadow_screen[i] = BLANK_CELL;
					end
					row        = ROWS - 1;
					did_scroll = 1'b1;
				end
			end
			OP_CLEAR: begin
				blank_screen();
				col = 0;
				row = 0;
			end
			OP_READ: begin
				if (idx < CELLS) begin
					read_value = shadow_screen[idx];
				end
			end
			default: begin
			end
		endcase
		shadow_col   = col;
		shadow_row   = row;
		res.col      = col[COL_W-1:0];
		res.row      = row[ROW_W-1:0];
		res.location = ADDR_W'(row * COLUMNS + col);
		res.data     = read_value;
		res.scrolled = did_scroll;
		return res;
	endfunction

	// Compares one result field, zero-extended to the widest field.
	function automatic void compare_field(input string field, input logic [CELL_W-1:0] want,
			input logic [CELL_W-1:0] got);
		if (got !== want) begin
			error_total++;
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, field, want, got);
		end
	endfunction

	// Result beats are checked first, then a new item's prediction is queued.
	always @(posedge clk or negedge arst_n) begin
		tcw_result_t want;
		if (!arst_n) begin
			blank_screen();
			shadow_col = 0;
			shadow_row = 0;
			pending_results.delete();
			error_total  = 0;
			result_total = 0;
			scroll_total = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_total++;
				if (pending_results.size() == 0) begin
					error_total++;
					$display("%0t ns: expected no result beat, got col %0d row %0d data 0x%0h",
						$time, cursor_col, cursor_row, cell_data);
				end else begin
					want = pending_results.pop_front();
					if (want.scrolled) begin
						scroll_total++;
					end
					compare_field("cursor_col", CELL_W'(want.col), CELL_W'(cursor_col));
					compare_field("cursor_row", CELL_W'(want.row), CELL_W'(cursor_row));
					compare_field("cursor_location", CELL_W'(want.location),
						CELL_W'(cursor_location));
					compare_field("cell_data", want.data, cell_data);
					compare_field("scrolled", CELL_W'(want.scrolled), CELL_W'(scrolled));
				end
			end
			if (in_valid && !in_stall) begin
				pending_results.push_back(predict_console_result(opcode, char_code,
					back_color, fore_color, cell_index));
			end
		end
		mismatches   <= error_total;
		outstanding  <= pending_results.size();
		results_seen <= result_total;
		scrolls_seen <= scroll_total;
	end

endmodule

/* verif/tb_text_console_writer_unit.sv */
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
	import tcw_pkg::*;

	localparam int               CYCLE_LIMIT = 500000;
	localparam int               WORK_TARGET = 850;
	localparam int               HOLD_AFTER  = 300;
	localparam int               HOLD_CYCLES = 400;
	localparam int               TAIL_CYCLES = 120;
	localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [OP_W-1:0]    opcode;
	logic [CHAR_W-1:0]  char_code;
	logic [COLOR_W-1:0] back_color;
	logic [COLOR_W-1:0] fore_color;
	logic [ADDR_W-1:0]  cell_index;
	logic               out_valid;
	logic               out_stall;
	logic [COL_W-1:0]   cursor_col;
	logic [ROW_W-1:0]   cursor_row;
	logic [ADDR_W-1:0]  cursor_location;
	logic [CELL_W-1:0]  cell_data;
	logic               scrolled;

	int mismatches;
	int outstanding;
	int results_seen;
	int scrolls_seen;
	int items_sent;
	int work_items;
	int reads_sent;
	int clears_sent;
	int burst_left;
	int cycle_count = 0;
	bit long_hold_done;

	text_console_writer_unit DUT (.*);

	console_result_checker result_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one beat and waits until it is taken; bursts usually end in a random gap.
	task automatic offer_beat(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg,
			input logic [ADDR_W-1:0] idx);
		in_valid   <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		back_color <= bg;
		fore_color <= fg;
		cell_index <= idx;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
		if (op == OP_CLEAR || op == OP_READ || (op == OP_PUT && (ch == CH_BS
				|| ch == CH_TAB || ch == CH_LF || ch == CH_CR
				|| (ch >= CH_SPACE && !ch[CHAR_W-1])))) begin
			work_items++;
		end
		if (op == OP_READ) begin
			reads_sent++;
		end
		if (op == OP_CLEAR) begin
			clears_sent++;
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] bg,
			input logic [COLOR_W-1:0] fg);
		offer_beat(OP_PUT, ch, bg, fg, ADDR_W'($urandom));
	endtask

	task automatic read_cell(input logic [ADDR_W-1:0] idx);
		offer_beat(OP_READ, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), idx);
	endtask

	// Stops offering until every outstanding result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	// Receiver: stretches of random stall density, plus one long hold-off.
	initial begin
		int stretch;
		int stall_pct;
		out_stall      = 1'b0;
		long_hold_done = 1'b0;
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stretch = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				repeat (stretch) begin
					out_stall <= ($urandom_range(0, 99) < stall_pct);
					@(posedge clk);
				end
			end
		end
	end

	// Sender: reset, directed items, then random segments of console traffic.
	initial begin
		int                 seg_len;
		int                 pick;
		int                 start;
		int                 k;
		bit                 mid_pause_done;
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] bg;
		logic [COLOR_W-1:0] fg;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = OP_PUT;
		char_code      = '0;
		back_color     = '0;
		fore_color     = '0;
		cell_index     = '0;
		items_sent     = 0;
		work_items     = 0;
		reads_sent     = 0;
		clears_sent    = 0;
		burst_left     = 1;
		mid_pause_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Blank screen at reset, color and character extremes, ignored bytes.
		read_cell('0);
		put_char(8'h41, 4'hF, 4'h0);
		put_char(8'h7F, 4'h0, 4'hF);
		put_char(8'h80, 4'h5, 4'hA);
		put_char(8'hFF, 4'hA, 4'h5);
		put_char(8'h00, 4'h3, 4'hC);
		// Cursor movement: backspace, tab, return, backspace at the left edge, newline.
		put_char(CH_BS, 4'h1, 4'h2);
		put_char(CH_TAB, 4'h1, 4'h2);
		put_char(CH_CR, 4'h1, 4'h2);
		put_char(CH_BS, 4'h1, 4'h2);
		put_char(CH_LF, 4'h1, 4'h2);
		// Reads of written, last, out-of-range and all-ones addresses.
		read_cell('0);
		read_cell(ADDR_W'(CELLS - 1));
		read_cell(ADDR_W'(CELLS));
		read_cell('1);
		offer_beat(OP_UNUSED, '1, '1, '1, '1);
		offer_beat(OP_CLEAR, CHAR_W'($urandom), '0, '0, '0);
		read_cell(ADDR_W'(1));
		// Tabs across a whole row until the column wraps.
		repeat (COLUMNS / TAB_WIDTH) put_char(CH_TAB, 4'h7, 4'h7);
		drain_results();

		// Enough newlines to force a scroll early on.
		repeat (ROWS + 2) put_char(CH_LF, COLOR_W'($urandom), COLOR_W'($urandom));

		while (work_items < WORK_TARGET) begin
			if (!mid_pause_done && work_items >= WORK_TARGET / 2) begin
				mid_pause_done = 1'b1;
				drain_results();
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// A line of text with an occasional cursor control and color change.
				seg_len = $urandom_range(1, COLUMNS + 15);
				bg      = COLOR_W'($urandom);
				fg      = COLOR_W'($urandom);
				for (k = 0; k < seg_len; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 8) begin
						bg = COLOR_W'($urandom);
						fg = COLOR_W'($urandom);
					end
					if (pick < 88) begin
						ch = CH_SPACE + CHAR_W'($urandom_range(0, 95));
					end else if (pick < 92) begin
						ch = CH_TAB;
					end else if (pick < 96) begin
						ch = CH_BS;
					end else begin
						ch = CH_CR;
					end
					put_char(ch, bg, fg);
				end
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					put_char(CH_CR, bg, fg);
				end
				if (pick < 75) begin
					put_char(CH_LF, bg, fg);
				end
			end else if (pick < 50) begin
				// A run of newlines, often long enough to scroll.
				seg_len = $urandom_range(1, ROWS + 5);
				repeat (seg_len) put_char(CH_LF, COLOR_W'($urandom), COLOR_W'($urandom));
			end else if (pick < 70) begin
				// Reads, either along a stretch of cells or scattered.
				seg_len = $urandom_range(1, 12);
				if ($urandom_range(0, 1) == 0) begin
					start = $urandom_range(0, CELLS - 1);
					for (k = 0; k < seg_len; k++) begin
						read_cell(ADDR_W'((start + k) % CELLS));
					end
				end else begin
					repeat (seg_len) begin
						pick = $urandom_range(0, 99);
						if (pick < 10) begin
							read_cell(ADDR_W'($urandom_range(CELLS, (1 << ADDR_W) - 1)));
						end else if (pick < 30) begin
							read_cell(ADDR_W'($urandom_range((ROWS - 1) * COLUMNS, CELLS - 1)));
						end else begin
							read_cell(ADDR_W'($urandom_range(0, CELLS - 1)));
						end
					end
				end
			end else if (pick < 85) begin
				// Fully random beats; clears are kept rare so the screen fills.
				seg_len = $urandom_range(1, 10);
				repeat (seg_len) begin
					ch = CHAR_W'($urandom);
					k  = $urandom_range(0, 99);
					offer_beat((k < 3) ? OP_CLEAR : (k < 60) ? OP_PUT
						: (k < 85) ? OP_READ : OP_UNUSED,
						ch, COLOR_W'($urandom), COLOR_W'($urandom), ADDR_W'($urandom));
				end
			end else if (pick < 97) begin
				// Control characters and bytes with the top bit set.
				seg_len = $urandom_range(1, 10);
				repeat (seg_len) begin
					pick = $urandom_range(0, 99);
					if (pick < 20) begin
						ch = CH_BS;
					end else if (pick < 40) begin
						ch = CH_TAB;
					end else if (pick < 50) begin
						ch = CH_CR;
					end else if (pick < 60) begin
						ch = CH_LF;
					end else if (pick < 80) begin
						ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
					end else begin
						ch = {1'b1, 7'($urandom)};
					end
					put_char(ch, COLOR_W'($urandom), COLOR_W'($urandom));
				end
			end else begin
				// Clear, then look at the home cell and the bottom row.
				offer_beat(OP_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom),
					COLOR_W'($urandom), ADDR_W'($urandom));
				read_cell('0);
				read_cell(ADDR_W'($urandom_range((ROWS - 1) * COLUMNS, CELLS - 1)));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d reads, %0d clears); %0d results checked, %0d scrolls.",
			items_sent, reads_sent, clears_sent, results_seen, scrolls_seen);
		$display("Output held off once for %0d cycles; %0d mismatches found.",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* text_console_writer_unit.f */
+incdir+design
design/tcw_pkg.sv
design/tcw_frame_ram.sv
design/tcw_ctrl.sv
design/text_console_writer_unit.sv
verif/console_result_checker.sv
verif/tb_text_console_writer_unit.sv
